// File: rtl/ccmh_pkg.sv
// Shared widths, register map and constant tables of the compass heading block.
package ccmh_pkg;

   localparam int PW = 52;   // projected vector component
   localparam int CW = 40;   // vectoring rotator x/y
   localparam int ZW = 26;   // angle accumulator, 2^-16 degree

   typedef logic signed [15:0] s16_type;
   typedef logic signed [17:0] s18_type;
   typedef logic signed [PW-1:0] proj_type;

   localparam logic [2:0] REG_OFFSET_X = 3'd0;
   localparam logic [2:0] REG_OFFSET_Y = 3'd1;
   localparam logic [2:0] REG_OFFSET_Z = 3'd2;
   localparam logic [2:0] REG_NORTH_X  = 3'd3;
   localparam logic [2:0] REG_NORTH_Y  = 3'd4;
   localparam logic [2:0] REG_NORTH_Z  = 3'd5;

   localparam s16_type RST_OFFSET_X = -16'sd1783;
   localparam s16_type RST_OFFSET_Y = 16'sd1906;
   localparam s16_type RST_OFFSET_Z = 16'sd6747;
   localparam s16_type RST_NORTH_X  = 16'sd1650;
   localparam s16_type RST_NORTH_Y  = 16'sd1650;
   localparam s16_type RST_NORTH_Z  = 16'sd10500;

   // Soft-iron matrix, Q2.14
   localparam s16_type SOFT_IRON [3][3] = '{
      '{ 16'sd17597,  -16'sd299, -16'sd4106 },
      '{ -16'sd299,  16'sd15078,  16'sd1566 },
      '{ -16'sd4106, 16'sd1566,   16'sd17688 }
   };

   localparam logic signed [ZW-1:0] DEG90_Q16  = 26'sd5898240;
   localparam logic signed [ZW-1:0] DEG180_Q16 = 26'sd11796480;
   localparam logic [14:0]          DEG90_OUT  = 15'd5760;

   localparam int ATAN_LEN = 24;
   localparam logic signed [ZW-1:0] ATAN_Q16 [ATAN_LEN] = '{
      26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379, 26'sd117304,
      26'sd58666, 26'sd29335, 26'sd14668, 26'sd7334, 26'sd3667, 26'sd1833,
      26'sd917, 26'sd458, 26'sd229, 26'sd115, 26'sd57, 26'sd29,
      26'sd14, 26'sd7, 26'sd4, 26'sd2, 26'sd1, 26'sd0
   };

endpackage

// File: rtl/tilt_compensated_compass_heading.sv
// Top level of the tilt-compensated compass heading pipeline.
//
//  channel   ports                           transaction
//  --------  ------------------------------  ---------------------------------------
//  request   start, busy, req_*              start high and busy low at the edge
//  result    rsp_valid, rsp_*                one-cycle strobe, taken at its end
//  config    psel, penable, pwrite, paddr,   write at the access phase edge
//            pwdata, prdata, pready
//
// One transaction enters every cycle; busy is always low. The result passes
// 3 calibration stages, 4 projection stages, 8 shrink/product stages, 32
// square-root stages (one result bit each), one pre-rotation stage, one stage
// per CORDIC iteration and a rounding stage. Reset clears the valid bits and
// loads register defaults.
// The receiver cannot stall, so the pipeline never holds.
module tilt_compensated_compass_heading #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_mag_x,
   input  logic [15:0] req_mag_y,
   input  logic [15:0] req_mag_z,
   input  logic [15:0] req_accel_x,
   input  logic [15:0] req_accel_y,
   input  logic [15:0] req_accel_z,
   output logic        rsp_valid,
   output logic signed [14:0] rsp_heading_raw,
   output logic signed [14:0] rsp_heading_calibrated,
   output logic        rsp_degenerate,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   ccmh_pkg::s16_type offset_ff [3];
   ccmh_pkg::s16_type north_ff  [3];
   ccmh_pkg::s16_type mag_in    [3];
   ccmh_pkg::s16_type acc_in    [3];
   ccmh_pkg::s16_type mdl_ff    [3][3];
   ccmh_pkg::s16_type gdl_ff    [3][3];
   ccmh_pkg::s18_type m_raw     [3];
   ccmh_pkg::s18_type n_raw     [3];
   ccmh_pkg::s18_type m_cal     [3];
   ccmh_pkg::s18_type n_cal     [3];
   ccmh_pkg::proj_type pm  [3];
   ccmh_pkg::proj_type pn  [3];
   ccmh_pkg::proj_type pmc [3];
   ccmh_pkg::proj_type pnc [3];
   logic accept;
   logic cal_m_vld, cal_n_vld, pm_vld, pn_vld, pmc_vld, pnc_vld;
   logic hr_vld, hc_vld, dg_raw, dg_cal;
   logic [14:0] hr, hc;

   assign busy   = 1'b0;
   assign pready = 1'b1;
   assign accept = start && !busy;

   assign mag_in = '{req_mag_x, req_mag_y, req_mag_z};
   assign acc_in = '{req_accel_x, req_accel_y, req_accel_z};

   // register file: write at the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '{ccmh_pkg::RST_OFFSET_X, ccmh_pkg::RST_OFFSET_Y, ccmh_pkg::RST_OFFSET_Z};
         north_ff  <= '{ccmh_pkg::RST_NORTH_X, ccmh_pkg::RST_NORTH_Y, ccmh_pkg::RST_NORTH_Z};
      end else if (psel && penable && pwrite && pready) begin
         case (paddr[4:2])
            ccmh_pkg::REG_OFFSET_X: offset_ff[0] <= pwdata[15:0];
            ccmh_pkg::REG_OFFSET_Y: offset_ff[1] <= pwdata[15:0];
            ccmh_pkg::REG_OFFSET_Z: offset_ff[2] <= pwdata[15:0];
            ccmh_pkg::REG_NORTH_X:  north_ff[0]  <= pwdata[15:0];
            ccmh_pkg::REG_NORTH_Y:  north_ff[1]  <= pwdata[15:0];
            ccmh_pkg::REG_NORTH_Z:  north_ff[2]  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         ccmh_pkg::REG_OFFSET_X: prdata = 32'(offset_ff[0]);
         ccmh_pkg::REG_OFFSET_Y: prdata = 32'(offset_ff[1]);
         ccmh_pkg::REG_OFFSET_Z: prdata = 32'(offset_ff[2]);
         ccmh_pkg::REG_NORTH_X:  prdata = 32'(north_ff[0]);
         ccmh_pkg::REG_NORTH_Y:  prdata = 32'(north_ff[1]);
         ccmh_pkg::REG_NORTH_Z:  prdata = 32'(north_ff[2]);
         default:                prdata = '0;
      endcase
   end

   // hold raw samples alongside the calibration stages
   always_ff @(posedge clock) begin
      mdl_ff[0] <= mag_in;
      gdl_ff[0] <= acc_in;
      for (int s = 1; s < 3; s++) begin
         mdl_ff[s] <= mdl_ff[s-1];
         gdl_ff[s] <= gdl_ff[s-1];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m_raw[i] = 18'(mdl_ff[2][i]);
         n_raw[i] = 18'(north_ff[i]);
      end
   end

   ccmh_calib u_cal_m (
      .clock, .reset, .in_valid(accept), .v(mag_in), .off(offset_ff),
      .out_valid(cal_m_vld), .c(m_cal)
   );

   ccmh_calib u_cal_n (
      .clock, .reset, .in_valid(accept), .v(north_ff), .off(offset_ff),
      .out_valid(cal_n_vld), .c(n_cal)
   );

   ccmh_project u_prj_m (
      .clock, .reset, .in_valid(cal_m_vld && cal_n_vld), .v(m_raw), .g(gdl_ff[2]),
      .out_valid(pm_vld), .p(pm)
   );

   ccmh_project u_prj_n (
      .clock, .reset, .in_valid(cal_m_vld), .v(n_raw), .g(gdl_ff[2]),
      .out_valid(pn_vld), .p(pn)
   );

   ccmh_project u_prj_mc (
      .clock, .reset, .in_valid(cal_m_vld), .v(m_cal), .g(gdl_ff[2]),
      .out_valid(pmc_vld), .p(pmc)
   );

   ccmh_project u_prj_nc (
      .clock, .reset, .in_valid(cal_n_vld), .v(n_cal), .g(gdl_ff[2]),
      .out_valid(pnc_vld), .p(pnc)
   );

   // heading = angle from projected north to projected field
   ccmh_angle #(.ITERATIONS(CORDIC_ITERATIONS)) u_ang_raw (
      .clock, .reset, .in_valid(pm_vld && pn_vld), .pa(pn), .pb(pm),
      .out_valid(hr_vld), .heading(hr), .degen(dg_raw)
   );

   ccmh_angle #(.ITERATIONS(CORDIC_ITERATIONS)) u_ang_cal (
      .clock, .reset, .in_valid(pmc_vld && pnc_vld), .pa(pnc), .pb(pmc),
      .out_valid(hc_vld), .heading(hc), .degen(dg_cal)
   );

   assign rsp_valid              = hr_vld && hc_vld;
   assign rsp_heading_raw        = hr;
   assign rsp_heading_calibrated = hc;
   assign rsp_degenerate         = dg_raw || dg_cal;

endmodule

// File: rtl/ccmh_calib.sv
// Hard-iron subtraction and soft-iron matrix, three register stages.
module ccmh_calib (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  ccmh_pkg::s16_type v      [3],
   input  ccmh_pkg::s16_type off    [3],
   output logic              out_valid,
   output ccmh_pkg::s18_type c      [3]
);

   logic signed [16:0] d_ff   [3];
   logic signed [32:0] prd_ff [3][3];
   logic signed [34:0] acc_in [3];
   ccmh_pkg::s18_type  c_ff   [3];
   logic [2:0]         vld_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc_in[r] = 35'(prd_ff[r][0]) + 35'(prd_ff[r][1]) + 35'(prd_ff[r][2]) + 35'sd8192;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
      for (int i = 0; i < 3; i++) begin
         d_ff[i] <= 17'(v[i]) - 17'(off[i]);
      end
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            prd_ff[r][k] <= 33'(ccmh_pkg::SOFT_IRON[r][k]) * 33'(d_ff[k]);
         end
         // floor((acc + 1/2)) in Q14
         c_ff[r] <= acc_in[r][31:14];
      end
   end

   assign out_valid = vld_ff[2];
   assign c         = c_ff;

endmodule

// File: rtl/ccmh_project.sv
// Projection of one vector onto the plane normal to gravity, four register stages.
module ccmh_project (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  ccmh_pkg::s18_type  v   [3],
   input  ccmh_pkg::s16_type  g   [3],
   output logic               out_valid,
   output ccmh_pkg::proj_type p   [3]
);

   ccmh_pkg::s18_type  v1_ff [3];
   ccmh_pkg::s18_type  v2_ff [3];
   ccmh_pkg::s18_type  v3_ff [3];
   ccmh_pkg::s16_type  g1_ff [3];
   ccmh_pkg::s16_type  g2_ff [3];
   logic signed [31:0] gsq_ff [3];
   logic signed [33:0] vgp_ff [3];
   logic signed [32:0] gg_ff;
   logic signed [35:0] vg_ff;
   logic signed [50:0] vgg_ff  [3];
   logic signed [50:0] gvg_ff  [3];
   logic               gz_ff;
   ccmh_pkg::proj_type p_ff [3];
   logic [3:0]         vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
      for (int i = 0; i < 3; i++) begin
         gsq_ff[i] <= 32'(g[i]) * 32'(g[i]);
         vgp_ff[i] <= 34'(v[i]) * 34'(g[i]);
         v1_ff[i]  <= v[i];
         g1_ff[i]  <= g[i];
         v2_ff[i]  <= v1_ff[i];
         g2_ff[i]  <= g1_ff[i];
         v3_ff[i]  <= v2_ff[i];
         vgg_ff[i] <= 51'(v2_ff[i]) * 51'(gg_ff);
         gvg_ff[i] <= 51'(vg_ff) * 51'(g2_ff[i]);
         // zero gravity passes the vector through
         p_ff[i]   <= gz_ff ? ccmh_pkg::PW'(v3_ff[i])
                            : ccmh_pkg::PW'(vgg_ff[i]) - ccmh_pkg::PW'(gvg_ff[i]);
      end
      gg_ff <= 33'(gsq_ff[0]) + 33'(gsq_ff[1]) + 33'(gsq_ff[2]);
      vg_ff <= 36'(vgp_ff[0]) + 36'(vgp_ff[1]) + 36'(vgp_ff[2]);
      gz_ff <= (gg_ff == '0);
   end

   assign out_valid = vld_ff[3];
   assign p         = p_ff;

endmodule

// File: rtl/ccmh_angle.sv
// Signed angle between two projected vectors: shrink, products, isqrt and CORDIC stages.
module ccmh_angle #(
   parameter int ITERATIONS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  ccmh_pkg::proj_type pa  [3],
   input  ccmh_pkg::proj_type pb  [3],
   output logic               out_valid,
   output logic [14:0]        heading,
   output logic               degen
);

   localparam int PW = ccmh_pkg::PW;
   localparam int CW = ccmh_pkg::CW;
   localparam int ZW = ccmh_pkg::ZW;

   typedef struct packed {
      logic signed [32:0] dot;
      logic               neg;
      logic               degen;
   } side_type;

   // shrink front end
   logic [PW-1:0]      maga_ff [3];
   logic [PW-1:0]      magb_ff [3];
   logic [PW-1:0]      maga2_ff [3];
   logic [PW-1:0]      magb2_ff [3];
   logic [PW-1:0]      maga3_ff [3];
   logic [PW-1:0]      magb3_ff [3];
   logic [2:0]         sgna_ff [3];
   logic [2:0]         sgnb_ff [3];
   logic [PW-1:0]      mxa_ff, mxb_ff;
   logic [5:0]         sha_in, shb_in, sha_ff, shb_ff;
   logic [PW-1:0]      mxa_in, mxb_in;
   ccmh_pkg::s16_type  ua_ff [3];
   ccmh_pkg::s16_type  ub_ff [3];
   logic [PW-1:0]      sha_val [3];
   logic [PW-1:0]      shb_val [3];
   logic signed [31:0] prd_ff [3][3];
   logic signed [32:0] dot_ff;
   logic signed [31:0] crs_ff [3];
   logic signed [63:0] sq_ff [3];
   logic signed [32:0] dot2_ff;
   logic [6:0]         neg_ff, deg_ff;
   logic [6:0]         vld_ff;

   // isqrt stages
   logic [63:0]        sq_n_ff [0:32];
   logic [63:0]        sq_r_ff [0:32];
   side_type           sq_s_ff [0:32];
   logic               sq_v_ff [0:32];

   // CORDIC stages
   logic signed [CW-1:0] cx_ff [0:ITERATIONS];
   logic signed [CW-1:0] cy_ff [0:ITERATIONS];
   logic signed [ZW-1:0] cz_ff [0:ITERATIONS];
   side_type             cs_ff [0:ITERATIONS];
   logic                 cv_ff [0:ITERATIONS];

   logic signed [ZW-1:0] zc_in;
   logic [ZW-1:0]        zr_in;
   logic [14:0]          ang_in;
   logic [14:0]          hd_ff;
   logic                 dg_ff, ov_ff;

   always_comb begin
      mxa_in = maga_ff[0];
      mxb_in = magb_ff[0];
      for (int i = 1; i < 3; i++) begin
         if (maga_ff[i] > mxa_in) mxa_in = maga_ff[i];
         if (magb_ff[i] > mxb_in) mxb_in = magb_ff[i];
      end
      // shift so that the largest magnitude drops below 2^15
      sha_in = '0;
      shb_in = '0;
      for (int k = 15; k < PW; k++) begin
         if (mxa_ff[k]) sha_in = 6'(k - 14);
         if (mxb_ff[k]) shb_in = 6'(k - 14);
      end
      for (int i = 0; i < 3; i++) begin
         sha_val[i] = maga3_ff[i] >> sha_ff;
         shb_val[i] = magb3_ff[i] >> shb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[5:0], in_valid};
      end
      // stage 1: magnitudes and flags
      for (int i = 0; i < 3; i++) begin
         maga_ff[i] <= pa[i][PW-1] ? PW'(-pa[i]) : PW'(pa[i]);
         magb_ff[i] <= pb[i][PW-1] ? PW'(-pb[i]) : PW'(pb[i]);
      end
      sgna_ff[0] <= {pa[2][PW-1], pa[1][PW-1], pa[0][PW-1]};
      sgnb_ff[0] <= {pb[2][PW-1], pb[1][PW-1], pb[0][PW-1]};
      neg_ff[0]  <= (pb[1] > 0);
      deg_ff[0]  <= (pa[0] == '0 && pa[1] == '0 && pa[2] == '0)
                 || (pb[0] == '0 && pb[1] == '0 && pb[2] == '0);
      // stage 2: largest magnitude
      mxa_ff   <= mxa_in;
      mxb_ff   <= mxb_in;
      maga2_ff <= maga_ff;
      magb2_ff <= magb_ff;
      // stage 3: shift amount
      sha_ff   <= sha_in;
      shb_ff   <= shb_in;
      maga3_ff <= maga2_ff;
      magb3_ff <= magb2_ff;
      sgna_ff[1] <= sgna_ff[0];
      sgnb_ff[1] <= sgnb_ff[0];
      sgna_ff[2] <= sgna_ff[1];
      sgnb_ff[2] <= sgnb_ff[1];
      // stage 4: shrunk, re-signed components
      for (int i = 0; i < 3; i++) begin
         ua_ff[i] <= sgna_ff[2][i] ? -16'(sha_val[i][15:0]) : 16'(sha_val[i][15:0]);
         ub_ff[i] <= sgnb_ff[2][i] ? -16'(shb_val[i][15:0]) : 16'(shb_val[i][15:0]);
      end
      // stage 5: all nine products
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prd_ff[i][j] <= 32'(ua_ff[i]) * 32'(ub_ff[j]);
         end
      end
      // stage 6: dot and cross
      dot_ff    <= 33'(prd_ff[0][0]) + 33'(prd_ff[1][1]) + 33'(prd_ff[2][2]);
      crs_ff[0] <= prd_ff[1][2] - prd_ff[2][1];
      crs_ff[1] <= prd_ff[2][0] - prd_ff[0][2];
      crs_ff[2] <= prd_ff[0][1] - prd_ff[1][0];
      // stage 7: squared cross components
      for (int i = 0; i < 3; i++) begin
         sq_ff[i] <= 64'(crs_ff[i]) * 64'(crs_ff[i]);
      end
      dot2_ff <= dot_ff;
      for (int k = 1; k < 7; k++) begin
         neg_ff[k] <= neg_ff[k-1];
         deg_ff[k] <= deg_ff[k-1];
      end
      // stage 8: squared length of the cross product
      sq_n_ff[0]       <= 64'(sq_ff[0]) + 64'(sq_ff[1]) + 64'(sq_ff[2]);
      sq_r_ff[0]       <= '0;
      sq_s_ff[0].dot   <= dot2_ff;
      sq_s_ff[0].neg   <= neg_ff[6];
      sq_s_ff[0].degen <= deg_ff[6];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else begin
         sq_v_ff[0] <= vld_ff[6];
      end
   end

   // one result bit per stage
   for (genvar k = 0; k < 32; k++) begin : g_sqrt
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      logic [63:0] trial;
      assign trial = sq_r_ff[k] + BIT;
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k+1] <= 1'b0;
         end else begin
            sq_v_ff[k+1] <= sq_v_ff[k];
         end
         if (sq_n_ff[k] >= trial) begin
            sq_n_ff[k+1] <= sq_n_ff[k] - trial;
            sq_r_ff[k+1] <= (sq_r_ff[k] >> 1) + BIT;
         end else begin
            sq_n_ff[k+1] <= sq_n_ff[k];
            sq_r_ff[k+1] <= sq_r_ff[k] >> 1;
         end
         sq_s_ff[k+1] <= sq_s_ff[k];
      end
   end

   // pre-rotate into the right half plane
   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff[0] <= 1'b0;
      end else begin
         cv_ff[0] <= sq_v_ff[32];
      end
      if (sq_s_ff[32].dot[32]) begin
         cx_ff[0] <= CW'(sq_r_ff[32]);
         cy_ff[0] <= -CW'(sq_s_ff[32].dot);
         cz_ff[0] <= ccmh_pkg::DEG90_Q16;
      end else begin
         cx_ff[0] <= CW'(sq_s_ff[32].dot);
         cy_ff[0] <= CW'(sq_r_ff[32]);
         cz_ff[0] <= '0;
      end
      cs_ff[0] <= sq_s_ff[32];
   end

   for (genvar k = 0; k < ITERATIONS; k++) begin : g_cordic
      logic signed [CW-1:0] xs, ys;
      assign xs = cx_ff[k] >>> k;
      assign ys = cy_ff[k] >>> k;
      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[k+1] <= 1'b0;
         end else begin
            cv_ff[k+1] <= cv_ff[k];
         end
         if (!cy_ff[k][CW-1]) begin
            cx_ff[k+1] <= cx_ff[k] + ys;
            cy_ff[k+1] <= cy_ff[k] - xs;
            cz_ff[k+1] <= cz_ff[k] + ccmh_pkg::ATAN_Q16[k];
         end else begin
            cx_ff[k+1] <= cx_ff[k] - ys;
            cy_ff[k+1] <= cy_ff[k] + xs;
            cz_ff[k+1] <= cz_ff[k] - ccmh_pkg::ATAN_Q16[k];
         end
         cs_ff[k+1] <= cs_ff[k];
      end
   end

   // clamp to [0, 180] degrees, round half up to 1/64 degree
   always_comb begin
      zc_in = cz_ff[ITERATIONS];
      if (zc_in[ZW-1]) zc_in = '0;
      if (zc_in > ccmh_pkg::DEG180_Q16) zc_in = ccmh_pkg::DEG180_Q16;
      zr_in  = ZW'(zc_in) + ZW'(512);
      ang_in = cs_ff[ITERATIONS].degen ? ccmh_pkg::DEG90_OUT : zr_in[24:10];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else begin
         ov_ff <= cv_ff[ITERATIONS];
      end
      hd_ff <= cs_ff[ITERATIONS].neg ? -ang_in : ang_in;
      dg_ff <= cs_ff[ITERATIONS].degen;
   end

   assign out_valid = ov_ff;
   assign heading   = hd_ff;
   assign degen     = dg_ff;

endmodule
